### src/msas_pkg.sv
// Shared types and constants of the multi-slot alarm scheduler.
// No dependencies; every other file but msas_ram imports this package.
package msas_pkg;

  // Default sizes of the slot table and time base
  localparam int NUM_SLOTS_DEF = 16;
  localparam int TIME_BITS_DEF = 48;

  // Fixed widths of the command and result words
  localparam int CMD_W   = 3;
  localparam int SLOT_FW = 4;
  localparam int DELAY_W = 48;
  localparam int GROUP_W = 32;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 3'd0,
    CMD_ONESHOT    = 3'd1,
    CMD_PERIODIC   = 3'd2,
    CMD_CANCEL     = 3'd3,
    CMD_CANCEL_GRP = 3'd4,
    CMD_SET_GRP    = 3'd5
  } cmd_t;

  // Result kinds
  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_FIRE = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD,
    ST_SCAN,
    ST_FLUSH,
    ST_GSCAN,
    ST_GACK
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // latch the accepted command word
    logic tick;        // advance the time counter
    logic scan_start;  // rewind the slot scan
    logic scan_adv;    // move the slot scan one step
    logic exec;        // perform a single-slot command and post its ack
    logic emit_flush;  // post the held fired word as the last one
    logic emit_gack;   // post the cancel-group ack
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;    // result register can take a word this cycle
    logic fire_hit;    // slot in the check stage fires
    logic pend_v;      // a fired word is held back
    logic scan_done;   // every slot has been checked
  } dp_stat_t;

endpackage

### src/msas_cmd_if.sv
// Command channel of the alarm scheduler: valid/ready plus command word.
// Depends on msas_pkg for field widths.
interface msas_cmd_if import msas_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [SLOT_FW-1:0] slot;
  logic [DELAY_W-1:0] delay;
  logic [DELAY_W-1:0] reload_interval;
  logic [GROUP_W-1:0] group_tag;

  modport source (output valid, command, slot, delay, reload_interval, group_tag,
                  input ready);
  modport sink   (input valid, command, slot, delay, reload_interval, group_tag,
                  output ready);
endinterface

### src/msas_res_if.sv
// Result channel of the alarm scheduler: valid/ready plus result word.
// Depends on msas_pkg for field widths.
interface msas_res_if import msas_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [SLOT_FW-1:0] fired_slot;
  logic               was_armed;
  logic               last;

  modport source (output valid, kind, fired_slot, was_armed, last, input ready);
  modport sink   (input valid, kind, fired_slot, was_armed, last, output ready);
endinterface

### src/msas_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module msas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/msas_ctrl.sv
// Sequencer of the alarm scheduler: takes command words, runs slot scans
// and paces result words. Depends on msas_pkg.
module msas_ctrl import msas_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] command,
  output logic             in_ready,
  output ctl_cmd_t         ctl,
  input  dp_stat_t         stat
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        // take no word while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          ctl.load = 1'b1;
          if (command inside {CMD_ONESHOT, CMD_PERIODIC, CMD_CANCEL, CMD_SET_GRP}) begin
            state_next = ST_CMD;
          end else if (command == CMD_TICK) begin
            ctl.tick       = 1'b1;
            ctl.scan_start = 1'b1;
            state_next     = ST_SCAN;
          end else if (command == CMD_CANCEL_GRP) begin
            ctl.scan_start = 1'b1;
            state_next     = ST_GSCAN;
          end
        end
      end
      ST_CMD: begin
        if (stat.out_free) begin
          ctl.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // hold the scan while a held word cannot be pushed out
        if (stat.scan_done) begin
          state_next = ST_FLUSH;
        end else if (!(stat.fire_hit && stat.pend_v && !stat.out_free)) begin
          ctl.scan_adv = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!stat.pend_v) begin
          state_next = ST_IDLE;
        end else if (stat.out_free) begin
          ctl.emit_flush = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_GSCAN: begin
        if (stat.scan_done) begin
          state_next = ST_GACK;
        end else begin
          ctl.scan_adv = 1'b1;
        end
      end
      ST_GACK: begin
        if (stat.out_free) begin
          ctl.emit_gack = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### src/msas_dp.sv
// Datapath of the alarm scheduler: time counter, slot tables, scan
// pipeline and result register. Depends on msas_pkg and msas_ram.
module msas_dp import msas_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ctl_cmd_t           ctl,
  output dp_stat_t           stat,
  input  logic [CMD_W-1:0]   command,
  input  logic [SLOT_FW-1:0] slot,
  input  logic [DELAY_W-1:0] delay,
  input  logic [DELAY_W-1:0] reload_interval,
  input  logic [GROUP_W-1:0] group_tag,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               kind,
  output logic [SLOT_FW-1:0] fired_slot,
  output logic               was_armed,
  output logic               last
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int TW     = 2 * TIME_BITS;

  // Latched command word
  logic [CMD_W-1:0]     cmd_q;
  logic [SLOT_FW-1:0]   slot_q;
  logic [TIME_BITS-1:0] delay_q;
  logic [TIME_BITS-1:0] ival_q;
  logic [GROUP_W-1:0]   tag_q;

  // Time and per-slot flags
  logic [TIME_BITS-1:0] now;
  logic [NUM_SLOTS-1:0] armed;
  logic [NUM_SLOTS-1:0] gvalid;

  // Scan pipeline
  logic [CNT_W-1:0]  rd_idx;
  logic              chk_v;
  logic [SLOT_W-1:0] chk_idx;
  logic              pend_v;
  logic [SLOT_W-1:0] pend_idx;

  // Memories
  logic              t_wr_en;
  logic [SLOT_W-1:0] t_wr_addr;
  logic [TW-1:0]     t_wr_data;
  logic [TW-1:0]     t_rd_data;
  logic              g_wr_en;
  logic [GROUP_W-1:0] g_rd_data;
  logic              rd_en;

  logic [SLOT_W-1:0]    si;
  logic                 slot_ok;
  logic                 at_end;
  logic [TIME_BITS-1:0] due_rd;
  logic [TIME_BITS-1:0] per_rd;
  logic [GROUP_W-1:0]   grp_val;
  logic                 fire_hit;
  logic                 grp_hit;
  logic                 is_set;
  logic                 cancel_was;

  assign si       = SLOT_W'(slot_q);
  assign slot_ok  = (int'(slot_q) < NUM_SLOTS);
  assign at_end   = (rd_idx == CNT_W'(NUM_SLOTS));
  assign due_rd   = t_rd_data[TW-1:TIME_BITS];
  assign per_rd   = t_rd_data[TIME_BITS-1:0];
  assign grp_val  = gvalid[chk_idx] ? g_rd_data : '0;
  assign fire_hit = chk_v && (cmd_q == CMD_TICK) && armed[chk_idx] && (due_rd <= now);
  assign grp_hit  = chk_v && (cmd_q == CMD_CANCEL_GRP) && (grp_val == tag_q);
  assign is_set   = (cmd_q == CMD_ONESHOT) || (cmd_q == CMD_PERIODIC);
  assign cancel_was = slot_ok && armed[si];
  assign rd_en    = ctl.scan_adv && !at_end;

  // Time table write port: set commands, or reload of a fired periodic slot
  always_comb begin
    t_wr_en   = 1'b0;
    t_wr_addr = chk_idx;
    t_wr_data = {now + per_rd, per_rd};
    if (ctl.exec && is_set && slot_ok) begin
      t_wr_en   = 1'b1;
      t_wr_addr = si;
      t_wr_data = {now + delay_q, (cmd_q == CMD_PERIODIC) ? ival_q : '0};
    end else if (ctl.scan_adv && fire_hit && (per_rd != '0)) begin
      t_wr_en = 1'b1;
    end
  end

  assign g_wr_en = ctl.exec && (cmd_q == CMD_SET_GRP) && slot_ok;

  msas_ram #(.WIDTH(TW), .DEPTH(NUM_SLOTS)) u_time_ram (
    .clk     (clk),
    .wr_en   (t_wr_en),
    .wr_addr (t_wr_addr),
    .wr_data (t_wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[SLOT_W-1:0]),
    .rd_data (t_rd_data)
  );

  msas_ram #(.WIDTH(GROUP_W), .DEPTH(NUM_SLOTS)) u_group_ram (
    .clk     (clk),
    .wr_en   (g_wr_en),
    .wr_addr (si),
    .wr_data (tag_q),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[SLOT_W-1:0]),
    .rd_data (g_rd_data)
  );

  // Latch the accepted command word
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q   <= command;
      slot_q  <= slot;
      delay_q <= TIME_BITS'(delay);
      ival_q  <= TIME_BITS'(reload_interval);
      tag_q   <= group_tag;
    end
  end

  // Time counter, flags, scan control and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      now       <= '0;
      armed     <= '0;
      gvalid    <= '0;
      rd_idx    <= '0;
      chk_v     <= 1'b0;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // post a result word, or drop it once taken
      if (ctl.exec || ctl.emit_flush || ctl.emit_gack ||
          (ctl.scan_adv && fire_hit && pend_v)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.tick) begin
        now <= now + 1'b1;
      end
      if (ctl.scan_start) begin
        rd_idx <= '0;
        chk_v  <= 1'b0;
        pend_v <= 1'b0;
      end
      if (ctl.scan_adv) begin
        // advance read stage into check stage
        if (!at_end) begin
          rd_idx <= rd_idx + 1'b1;
          chk_v  <= 1'b1;
        end else begin
          chk_v <= 1'b0;
        end
        // fire: disarm one-shot, hold the word, push the previous one
        if (fire_hit) begin
          if (per_rd == '0) begin
            armed[chk_idx] <= 1'b0;
          end
          pend_v <= 1'b1;
        end
        if (grp_hit) begin
          armed[chk_idx] <= 1'b0;
        end
      end
      if (ctl.exec) begin
        if (slot_ok) begin
          if (is_set) begin
            armed[si] <= 1'b1;
          end else if (cmd_q == CMD_CANCEL) begin
            armed[si] <= 1'b0;
          end else if (cmd_q == CMD_SET_GRP) begin
            gvalid[si] <= 1'b1;
          end
        end
      end
      if (ctl.emit_flush) begin
        pend_v <= 1'b0;
      end
    end
  end

  // Scan indexes and result payload
  always_ff @(posedge clk) begin
    if (rd_en) begin
      chk_idx <= rd_idx[SLOT_W-1:0];
    end
    if (ctl.scan_adv && fire_hit) begin
      pend_idx <= chk_idx;
      if (pend_v) begin
        kind       <= KIND_FIRE;
        fired_slot <= SLOT_FW'(pend_idx);
        was_armed  <= 1'b0;
        last       <= 1'b0;
      end
    end
    if (ctl.exec) begin
      kind       <= KIND_ACK;
      fired_slot <= slot_q;
      was_armed  <= (cmd_q == CMD_CANCEL) ? cancel_was : 1'b0;
      last       <= 1'b1;
    end
    if (ctl.emit_flush) begin
      kind       <= KIND_FIRE;
      fired_slot <= SLOT_FW'(pend_idx);
      was_armed  <= 1'b0;
      last       <= 1'b1;
    end
    if (ctl.emit_gack) begin
      kind       <= KIND_ACK;
      fired_slot <= '0;
      was_armed  <= 1'b0;
      last       <= 1'b1;
    end
  end

  // Status to the sequencer
  always_comb begin
    stat.out_free  = !out_valid || out_ready;
    stat.fire_hit  = fire_hit;
    stat.pend_v    = pend_v;
    stat.scan_done = at_end && !chk_v;
  end

endmodule

### src/multi_slot_alarm_scheduler.sv
// Top level of the multi-slot alarm scheduler: sequencer plus datapath.
// Depends on msas_pkg, msas_cmd_if, msas_res_if, msas_ctrl, msas_dp.
//
//   channel  dir  word
//   cmd      in   command, slot, delay, reload_interval, group_tag
//   res      out  kind, fired_slot, was_armed, last
//
// A set, cancel or set-group command is accepted, then executed once the
// result register is free, posting its ack. A tick or cancel-group runs
// the slot scan that reads one table entry per cycle from the slot RAMs.
// Reset is synchronous; slots read as disarmed and group 0 at once.
// A stalled result register holds the scan until the held word can move.
module multi_slot_alarm_scheduler import msas_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  msas_cmd_if.sink  cmd,
  msas_res_if.source res
);

  ctl_cmd_t ctl;
  dp_stat_t stat;

  msas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .command  (cmd.command),
    .in_ready (cmd.ready),
    .ctl      (ctl),
    .stat     (stat)
  );

  msas_dp #(.NUM_SLOTS(NUM_SLOTS), .TIME_BITS(TIME_BITS)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .stat            (stat),
    .command         (cmd.command),
    .slot            (cmd.slot),
    .delay           (cmd.delay),
    .reload_interval (cmd.reload_interval),
    .group_tag       (cmd.group_tag),
    .out_ready       (res.ready),
    .out_valid       (res.valid),
    .kind            (res.kind),
    .fired_slot      (res.fired_slot),
    .was_armed       (res.was_armed),
    .last            (res.last)
  );

endmodule
